>>> rtl/core/phd_pkg.sv
package phd_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		STATUS_HEADER    = 3'd0,
		STATUS_HDR_DONE  = 3'd1,
		STATUS_PAYLOAD   = 3'd2,
		STATUS_ZERO_CTRL = 3'd3,
		STATUS_TOO_LONG  = 3'd4,
		STATUS_BAD_TYPE  = 3'd5,
		STATUS_HALTED    = 3'd6
	} status_t;

	// Field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 24;
	localparam int unsigned MAXL_W  = 25;
	localparam int unsigned TSIZE_W = 4;
	localparam int unsigned TNAME_W = 64;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	// Register index of max_packet_length
	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic [MAXL_W-1:0] MAX_LEN_RESET = 25'd65536;

	// Flag bits of the control byte
	localparam int unsigned FL_RESERVED = 0;
	localparam int unsigned FL_BIG      = 1;
	localparam int unsigned FL_COMPOUND = 2;

	// Legal type byte range
	localparam logic [BYTE_W-1:0] TYPE_LO = 8'h21;
	localparam logic [BYTE_W-1:0] TYPE_HI = 8'h7E;

endpackage

>>> rtl/core/phd_ifs.sv
// Byte stream channel
interface phd_byte_if;
	logic                         valid;
	logic                         ready;
	logic [phd_pkg::BYTE_W-1:0]   data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

// Decoded result channel
interface phd_result_if;
	logic                          valid;
	logic                          ready;
	phd_pkg::status_t              status;
	logic [phd_pkg::BYTE_W-1:0]    out_byte;
	logic [phd_pkg::LEN_W-1:0]     payload_length;
	logic [phd_pkg::TSIZE_W-1:0]   type_size;
	logic [phd_pkg::TNAME_W-1:0]   type_name;
	logic                          big_endian_flag;
	logic                          compound_flag;
	logic                          reserved_flag;
	logic                          packet_end;

	modport source(
		output valid, output status, output out_byte, output payload_length,
		output type_size, output type_name, output big_endian_flag,
		output compound_flag, output reserved_flag, output packet_end,
		input ready
	);
	modport sink(
		input valid, input status, input out_byte, input payload_length,
		input type_size, input type_name, input big_endian_flag,
		input compound_flag, input reserved_flag, input packet_end,
		output ready
	);
endinterface

>>> rtl/core/packet_header_deframer.sv
// A byte taken from the stream is held in the input byte register and its
// result in the result register. One byte per cycle while the result channel
// takes results; the header parse is one pass of logic between the two.
// Reset (arst_n low, asynchronous): parser waits for a control byte,
// decode state cleared, max_packet_length = 65536, both stages empty.
module packet_header_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	phd_byte_if.sink                          stream,
	phd_result_if.source                      result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [phd_pkg::ADDR_W-1:0]        paddr,
	input  logic [phd_pkg::DATA_W-1:0]        pwdata,
	output logic [phd_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	typedef enum logic [2:0] {
		PH_CONTROL = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_TYPE    = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_HALT    = 3'd4
	} phase_t;

	// Configuration
	logic [phd_pkg::MAXL_W-1:0] max_len_q;

	// Parser state
	phase_t                       phase_q, phase_n;
	logic [phd_pkg::LEN_W-1:0]    len_q, len_n;
	logic [1:0]                   lcnt_q, lcnt_n;
	logic [phd_pkg::TSIZE_W-1:0]  tcnt_q, tcnt_n;
	logic [2:0]                   flags_q, flags_n;
	logic [phd_pkg::LEN_W-1:0]    bcnt_q, bcnt_n;
	logic [phd_pkg::TNAME_W-1:0]  tname_q, tname_n;

	// Stage registers
	logic                         valid_s1;
	logic [phd_pkg::BYTE_W-1:0]   byte_s1;
	logic                         valid_s2;
	phd_pkg::status_t             status_s2, status_n;
	logic [phd_pkg::BYTE_W-1:0]   obyte_s2, obyte_n;
	logic [phd_pkg::LEN_W-1:0]    len_s2;
	logic [phd_pkg::TSIZE_W-1:0]  tcnt_s2;
	logic [phd_pkg::TNAME_W-1:0]  tname_s2;
	logic [2:0]                   flags_s2;
	logic                         pend_s2, pend_n;

	logic advance;

	// Total packet size check: payload + length bytes + type bytes + control
	function automatic logic size_ok(
		input logic [phd_pkg::LEN_W-1:0]   lv,
		input logic [1:0]                  lc,
		input logic [phd_pkg::TSIZE_W-1:0] tc,
		input logic [phd_pkg::MAXL_W-1:0]  lim
	);
		logic [phd_pkg::MAXL_W-1:0] total;
		total = {1'b0, lv} + {23'b0, lc} + {21'b0, tc} + 25'd1;
		return total <= lim;
	endfunction

	// APB register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == phd_pkg::REG_MAX_LEN) ? {7'b0, max_len_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= phd_pkg::MAX_LEN_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == phd_pkg::REG_MAX_LEN) begin
			max_len_q <= pwdata[phd_pkg::MAXL_W-1:0];
		end
	end

	// Handshakes: stage 1 moves on when the result stage is free or drains
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign stream.ready = !valid_s1 || advance;

	// One parse step on the byte held in stage 1
	always_comb begin
		phase_n  = phase_q;
		len_n    = len_q;
		lcnt_n   = lcnt_q;
		tcnt_n   = tcnt_q;
		flags_n  = flags_q;
		bcnt_n   = bcnt_q;
		tname_n  = tname_q;
		status_n = phd_pkg::STATUS_HEADER;
		obyte_n  = byte_s1;
		pend_n   = 1'b0;
		unique case (phase_q)
			PH_CONTROL: begin
				if (byte_s1 == '0) begin
					status_n = phd_pkg::STATUS_ZERO_CTRL;
					phase_n  = PH_HALT;
				end else begin
					lcnt_n  = byte_s1[7:6];
					tcnt_n  = {1'b0, byte_s1[5:3]} + 4'd1;
					flags_n = byte_s1[2:0];
					len_n   = '0;
					tname_n = '0;
					bcnt_n  = '0;
					if (byte_s1[7:6] == 2'd0) begin
						if (!size_ok('0, 2'd0, tcnt_n, max_len_q)) begin
							status_n = phd_pkg::STATUS_TOO_LONG;
							phase_n  = PH_HALT;
						end else begin
							// no length bytes: length is zero, compound drops
							flags_n[phd_pkg::FL_COMPOUND] = 1'b0;
							phase_n = PH_TYPE;
						end
					end else begin
						phase_n = PH_LENGTH;
					end
				end
			end
			PH_LENGTH: begin
				if (flags_q[phd_pkg::FL_BIG]) begin
					len_n = {len_q[15:0], byte_s1};
				end else begin
					len_n = len_q | ({16'b0, byte_s1} << {bcnt_q[1:0], 3'b000});
				end
				bcnt_n = bcnt_q + 24'd1;
				if (bcnt_n >= {22'b0, lcnt_q}) begin
					if (!size_ok(len_n, lcnt_q, tcnt_q, max_len_q)) begin
						status_n = phd_pkg::STATUS_TOO_LONG;
						phase_n  = PH_HALT;
					end else begin
						if (len_n == '0) begin
							flags_n[phd_pkg::FL_COMPOUND] = 1'b0;
						end
						bcnt_n  = '0;
						phase_n = PH_TYPE;
					end
				end
			end
			PH_TYPE: begin
				if (byte_s1 < phd_pkg::TYPE_LO || byte_s1 > phd_pkg::TYPE_HI) begin
					status_n = phd_pkg::STATUS_BAD_TYPE;
					phase_n  = PH_HALT;
				end else begin
					tname_n = tname_q | ({56'b0, byte_s1} << {bcnt_q[2:0], 3'b000});
					bcnt_n  = bcnt_q + 24'd1;
					if (bcnt_n >= {20'b0, tcnt_q}) begin
						status_n = phd_pkg::STATUS_HDR_DONE;
						if (len_q == '0) begin
							pend_n  = 1'b1;
							bcnt_n  = '0;
							phase_n = PH_CONTROL;
						end else begin
							bcnt_n  = len_q;
							phase_n = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				status_n = phd_pkg::STATUS_PAYLOAD;
				bcnt_n   = bcnt_q - 24'd1;
				if (bcnt_n == '0) begin
					pend_n  = 1'b1;
					phase_n = PH_CONTROL;
				end
			end
			default: begin
				// halted: only reset gets out
				status_n = phd_pkg::STATUS_HALTED;
				obyte_n  = '0;
				phase_n  = PH_HALT;
			end
		endcase
	end

	// Stage 1: input byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
			if (stream.valid) begin
				byte_s1 <= stream.data_byte;
			end
		end
	end

	// Parser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CONTROL;
			len_q     <= '0;
			lcnt_q    <= '0;
			tcnt_q    <= '0;
			flags_q   <= '0;
			bcnt_q    <= '0;
			tname_q   <= '0;
			valid_s2  <= 1'b0;
			status_s2 <= phd_pkg::STATUS_HEADER;
			obyte_s2  <= '0;
			len_s2    <= '0;
			tcnt_s2   <= '0;
			tname_s2  <= '0;
			flags_s2  <= '0;
			pend_s2   <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_n;
			len_q     <= len_n;
			lcnt_q    <= lcnt_n;
			tcnt_q    <= tcnt_n;
			flags_q   <= flags_n;
			bcnt_q    <= bcnt_n;
			tname_q   <= tname_n;
			valid_s2  <= 1'b1;
			status_s2 <= status_n;
			obyte_s2  <= obyte_n;
			len_s2    <= len_n;
			tcnt_s2   <= tcnt_n;
			tname_s2  <= tname_n;
			flags_s2  <= flags_n;
			pend_s2   <= pend_n;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result channel
	assign result.valid           = valid_s2;
	assign result.status          = status_s2;
	assign result.out_byte        = obyte_s2;
	assign result.payload_length  = len_s2;
	assign result.type_size       = tcnt_s2;
	assign result.type_name       = tname_s2;
	assign result.big_endian_flag = flags_s2[phd_pkg::FL_BIG];
	assign result.compound_flag   = flags_s2[phd_pkg::FL_COMPOUND];
	assign result.reserved_flag   = flags_s2[phd_pkg::FL_RESERVED];
	assign result.packet_end      = pend_s2;

`ifndef ASSERT_OFF
	// Errors are sticky
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("parser left halt without reset");

	// Halted results carry no byte
	a_halt_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == phd_pkg::STATUS_HALTED |-> result.out_byte == '0)
		else $error("halted result carries a byte");

	// Packet end only on the last type byte or a payload byte
	a_pend_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.packet_end |->
		(result.status == phd_pkg::STATUS_HDR_DONE
		|| result.status == phd_pkg::STATUS_PAYLOAD))
		else $error("packet end on a wrong status");

	// Input stalls only when both stages are full and the result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> valid_s1 && valid_s2 && !result.ready)
		else $error("input stalled without back pressure");

	// Empty packets never report compound
	a_compound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == phd_pkg::STATUS_HDR_DONE
		&& result.payload_length == '0 |-> !result.compound_flag)
		else $error("compound flag set on a zero length packet");
`endif

endmodule
